@@ hw/rtl/sli_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted list package
// Shared codes and the command and status groups that pass between the
// controller and the datapath of the sorted list.
// ----------------------------------------------------------------------------
`default_nettype none

package sli_pkg;

   typedef enum logic {
      ACTION_INSERT = 1'b0,
      ACTION_DELETE = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_done;
   } dp_stat_type;

endpackage

`default_nettype wire

@@ hw/rtl/sli_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/sli_datapath.sv @@
// ----------------------------------------------------------------------------
// Sorted list datapath
// Holds the operand, the entry count and the table memory, and ripples the
// stored values one place per cycle during an insert or a delete.
// ----------------------------------------------------------------------------
`default_nettype none

module sli_datapath #(
   parameter int CAPACITY    = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire sli_pkg::dp_cmd_type               cmd,
   output sli_pkg::dp_stat_type                   stat,
   input  wire logic                              req_action,
   input  wire logic signed [VALUE_WIDTH-1:0]     req_value,
   output logic [1:0]                             rsp_status,
   output logic [$clog2(CAPACITY+1)-1:0]          rsp_entry_count,
   output logic signed [VALUE_WIDTH-1:0]          rsp_top_value
);

   import sli_pkg::*;

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   logic                   action_ff, action_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                   pend_ff, pend_in;
   logic [CNT_W-1:0]       pidx_ff, pidx_in;
   logic                   flag_ff, flag_in;
   logic [VALUE_WIDTH-1:0] carry_ff, carry_in;
   logic [VALUE_WIDTH-1:0] top_ff, top_in;
   status_type             status_ff, status_in;

   logic                   full;
   logic                   avail;
   logic                   more;
   logic                   is_insert;
   logic [VALUE_WIDTH-1:0] old_value;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [VALUE_WIDTH-1:0] wr_data;

   sli_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (more),
      .rd_addr (rd_idx_ff[ADDR_W-1:0]),
      .rd_data (old_value)
   );

   always_comb begin
      is_insert      = (action_ff == ACTION_INSERT);
      full           = (count_ff == CNT_W'(CAPACITY));
      avail          = (rd_idx_ff < count_ff) && !(is_insert && full);
      more           = cmd.scan && avail;
      stat.scan_done = !pend_ff && !avail;

      action_in = action_ff;
      value_in  = value_ff;
      count_in  = count_ff;
      rd_idx_in = rd_idx_ff;
      pend_in   = pend_ff;
      pidx_in   = pidx_ff;
      flag_in   = flag_ff;
      carry_in  = carry_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = pidx_ff[ADDR_W-1:0];
      wr_data   = carry_ff;

      if (cmd.load) begin
         action_in = req_action;
         value_in  = req_value;
         rd_idx_in = '0;
         pend_in   = 1'b0;
         flag_in   = 1'b0;
      end

      if (cmd.scan) begin
         rd_idx_in = more ? rd_idx_ff + CNT_W'(1) : rd_idx_ff;
         pend_in   = more;
         pidx_in   = rd_idx_ff;
         if (pend_ff) begin
            if (is_insert) begin
               if (flag_ff) begin
                  wr_en    = 1'b1;
                  wr_data  = carry_ff;
                  carry_in = old_value;
               end else if ($signed(old_value) <= $signed(value_ff)) begin
                  wr_en    = 1'b1;
                  wr_data  = value_ff;
                  carry_in = old_value;
                  flag_in  = 1'b1;
               end
            end else begin
               if (flag_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = pidx_ff[ADDR_W-1:0] - ADDR_W'(1);
                  wr_data = old_value;
               end else if (old_value == value_ff) begin
                  flag_in = 1'b1;
               end
            end
         end
      end

      if (cmd.finish) begin
         if (is_insert) begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               wr_en     = 1'b1;
               wr_addr   = count_ff[ADDR_W-1:0];
               wr_data   = flag_ff ? carry_ff : value_ff;
               count_in  = count_ff + CNT_W'(1);
               status_in = STATUS_DONE;
            end
         end else begin
            if (flag_ff) begin
               count_in  = count_ff - CNT_W'(1);
               status_in = STATUS_DONE;
            end else begin
               status_in = STATUS_NOT_FOUND;
            end
         end
      end

      top_in = (wr_en && (wr_addr == '0)) ? wr_data : top_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rd_idx_ff <= '0;
         pend_ff   <= 1'b0;
         flag_ff   <= 1'b0;
         status_ff <= STATUS_DONE;
      end else begin
         count_ff  <= count_in;
         rd_idx_ff <= rd_idx_in;
         pend_ff   <= pend_in;
         flag_ff   <= flag_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action_in;
      value_ff  <= value_in;
      pidx_ff   <= pidx_in;
      carry_ff  <= carry_in;
      top_ff    <= top_in;
   end

   assign rsp_status      = status_ff;
   assign rsp_entry_count = count_ff;
   assign rsp_top_value   = (count_ff == '0) ? '0 : top_ff;

endmodule

`default_nettype wire

@@ hw/rtl/sli_controller.sv @@
// ----------------------------------------------------------------------------
// Sorted list controller
// Sequences one operation: load the word, scan the table, finish, respond.
// ----------------------------------------------------------------------------
`default_nettype none

module sli_controller (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   output logic                      rsp_strobe,
   output sli_pkg::dp_cmd_type       cmd,
   input  wire sli_pkg::dp_stat_type stat
);

   import sli_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_FINISH = 4'b0100,
      ST_RESP   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      rsp_strobe = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            rsp_strobe = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

@@ hw/rtl/sorted_list_insert_delete.sv @@
// ----------------------------------------------------------------------------
// Sorted list with insert and delete
// Keeps up to CAPACITY signed values in descending order in a RAM and
// answers every insert or delete word with status, count and largest value.
// ----------------------------------------------------------------------------
// From start, the controller steps through the scan, finish and response states;
// the scan reads no entries when the table is empty or an insert finds it full.
// A new word is taken only once the controller is idle again;
// busy stays high through the response cycle.
// The scan reads one entry per cycle through the single RAM read port.
// The response is shown for one cycle; the receiver cannot stall it.
// Synchronous reset empties the table; no clearing pass is needed.
`default_nettype none

module sorted_list_insert_delete #(
   parameter int CAPACITY    = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_action,
   input  wire logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                               rsp_strobe,
   output logic [1:0]                         rsp_status,
   output logic [$clog2(CAPACITY+1)-1:0]      rsp_entry_count,
   output logic signed [VALUE_WIDTH-1:0]      rsp_top_value
);

   import sli_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   sli_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .stat       (stat)
   );

   sli_datapath #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_action      (req_action),
      .req_value       (req_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_top_value   (rsp_top_value)
   );

endmodule

`default_nettype wire
